### src/slot_cache_store_policy_defines.svh
// Assertion macros for the slot cache store policy checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SLOT_CACHE_STORE_POLICY_DEFINES_SVH
`define SLOT_CACHE_STORE_POLICY_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define SCSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scsp: check failed");

// Next-cycle implication, off while reset is held.
`define SCSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scsp: check failed");

`endif

### src/scsp_pkg.sv
// Shared constants, codes and types of the slot cache store policy.
// No dependencies; every module but scsp_ram imports it.
package scsp_pkg;

    localparam int ENTRIES    = 64;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int TIME_BITS  = 48;
    localparam int TIME_W     = 48;
    localparam int FREQ_W     = 16;
    localparam int SLOT_W     = 6;
    localparam int TOL_W      = 16;
    localparam int AGE_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(48);
    localparam logic [AGE_W-1:0] AGE_RESET = AGE_W'(60000);

    // slot length in ms; parity is floor(t / SLOT_MS) mod 2
    localparam int SLOT_MS     = 15000;
    localparam int DIV_DIGIT   = 4;
    localparam int DIV_STEPS   = (TIME_BITS + DIV_DIGIT - 1) / DIV_DIGIT;
    localparam int DIV_W       = DIV_STEPS * DIV_DIGIT;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int REM_W       = $clog2(SLOT_MS);

    localparam int WORD_W = 1 + FREQ_W + TIME_BITS;

    typedef enum logic [1:0] {
        PL_MATCH   = 2'd0,
        PL_FREE    = 2'd1,
        PL_EVICT   = 2'd2,
        PL_CLEARED = 2'd3
    } t_place;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ_TOL = 1'b0,
        CFG_MAX_AGE  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                 action;
        logic [FREQ_W-1:0]    freq;
        logic [TIME_BITS-1:0] now;
    } t_job;

    typedef struct packed {
        logic [TOL_W-1:0] freq_tol;
        logic [AGE_W-1:0] max_age;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] slot;
        t_place           placement;
    } t_result;

    typedef struct packed {
        logic                 parity;
        logic [FREQ_W-1:0]    freq;
        logic [TIME_BITS-1:0] stamp;
    } t_entry;

endpackage

### src/scsp_if.sv
// Channel interfaces: request, response and register write.
// Depends on scsp_pkg for field widths.
interface scsp_req_if;
    import scsp_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [FREQ_W-1:0] freq;
    logic [TIME_W-1:0] time_ms;
    modport source (output valid, action, freq, time_ms, input ready);
    modport sink   (input valid, action, freq, time_ms, output ready);
endinterface

interface scsp_rsp_if;
    import scsp_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot_index;
    logic [1:0]        placement;
    modport source (output valid, slot_index, placement, input ready);
    modport sink   (input valid, slot_index, placement, output ready);
endinterface

interface scsp_cfg_if;
    import scsp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/slot_cache_store_policy.sv
// Top level of the slot cache store policy: register port, request intake,
// response register. Uses scsp_pkg, scsp_if and scsp_scan.
//
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   action, freq, time_ms
//  o_rsp     out  valid/ready   slot_index, placement
//  i_cfg     in   valid/ready   index (0 freq tolerance, 1 max age), data
//
// One request at a time. A clear passes through the engine's DONE state into
// the response register. A store first finds the slot parity (4 quotient bits
// per cycle, 12 steps at 48-bit time), then reads entries one by one through
// the single RAM read port (a match ends the scan early) and then writes the
// chosen entry. Synchronous active-low reset empties the table (valid bits in
// flops) and loads register defaults; no clearing pass.
// The response register lets the next request in while a response stalls;
// the engine itself holds its result until that register is free.
module slot_cache_store_policy (
    input  logic  i_clk,
    input  logic  i_rst_n,
    scsp_req_if.sink   i_req,
    scsp_rsp_if.source o_rsp,
    scsp_cfg_if.sink   i_cfg
);
    import scsp_pkg::*;

    t_cfg    r_cfg;
    t_result r_out;
    logic    r_out_vld;

    t_job    job;
    t_result result;
    logic    busy;
    logic    done;
    logic    start;
    logic    take;

    // registers always writable; writes must come only while idle (unchecked)
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq_tol <= TOL_RESET;
            r_cfg.max_age  <= AGE_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_FREQ_TOL: r_cfg.freq_tol <= i_cfg.data[TOL_W-1:0];
                CFG_MAX_AGE:  r_cfg.max_age  <= i_cfg.data[AGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // request intake; time is reduced to TIME_BITS
    assign job         = '{action: i_req.action, freq: i_req.freq,
                           now: TIME_BITS'(i_req.time_ms)};
    assign i_req.ready = !busy;
    assign start       = i_req.valid && !busy;
    assign take        = !r_out_vld || o_rsp.ready;

    scsp_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_job    (job),
        .i_cfg    (r_cfg),
        .o_busy   (busy),
        .o_done   (done),
        .o_result (result),
        .i_take   (take)
    );

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (done && take) begin
            r_out_vld <= 1'b1;
            r_out     <= result;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.slot_index = SLOT_W'(r_out.slot);
    assign o_rsp.placement  = r_out.placement;
endmodule

### src/scsp_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module scsp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/scsp_parity.sv
// Slot parity unit: long division of the timestamp by the slot length,
// DIV_DIGIT quotient bits per cycle; keeps only the quotient LSB. Uses scsp_pkg.
module scsp_parity (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [scsp_pkg::TIME_BITS-1:0] i_now,
    output logic                           o_done,
    output logic                           o_parity
);
    import scsp_pkg::*;

    localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(SLOT_MS);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_par;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_shift;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     n_rem;
    logic                 n_q;
    logic [REM_W:0]       trial;

    // restoring division, one digit of DIV_DIGIT bits per cycle
    always_comb begin
        n_rem = r_rem;
        n_q   = 1'b0;
        trial = '0;
        for (int k = 0; k < DIV_DIGIT; k++) begin
            trial = {n_rem, r_shift[DIV_W-1-k]};
            if (trial >= DIVISOR) begin
                trial = trial - DIVISOR;
                n_q   = 1'b1;
            end else begin
                n_q   = 1'b0;
            end
            n_rem = trial[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // one-cycle pulse after the last digit
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= DIV_CNT_W'(DIV_STEPS - 1);
                r_shift <= DIV_W'(i_now);
                r_rem   <= '0;
            end else if (r_busy) begin
                r_shift <= r_shift << DIV_DIGIT;
                r_rem   <= n_rem;
                r_par   <= n_q;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_parity = r_par;
endmodule

### src/scsp_scan.sv
// Table scan engine: entry RAM, valid bits, sequencer and slot choice.
// Uses scsp_pkg, scsp_ram and scsp_parity.
module scsp_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  scsp_pkg::t_job      i_job,
    input  scsp_pkg::t_cfg      i_cfg,
    output logic                o_busy,
    output logic                o_done,
    output scsp_pkg::t_result   o_result,
    input  logic                i_take
);
    import scsp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SCAN = 5'b00100,
        S_PICK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    t_state               r_state;
    t_state               n_state;
    logic [ENTRIES-1:0]   r_valid;
    logic [FREQ_W-1:0]    r_freq;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_par;
    logic [IDX_W-1:0]     r_rd_addr;
    logic                 r_rd_more;
    logic                 r_ev_vld;
    logic [IDX_W-1:0]     r_ev_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_chosen;
    t_place               r_kind;
    logic                 r_have_old;
    logic [IDX_W-1:0]     r_old_idx;
    logic [TIME_BITS-1:0] r_old_t;

    logic                 par_start;
    logic                 par_done;
    logic                 par_bit;
    logic                 ram_we;
    logic                 ram_re;
    logic [WORD_W-1:0]    ram_rdata;
    t_entry               rd;
    t_entry               wr;
    logic [IDX_W-1:0]     wsel;
    logic                 live;
    logic [FREQ_W-1:0]    fdiff;
    logic                 hit;
    logic [TIME_BITS-1:0] age;
    logic                 expired;
    logic                 older;
    logic                 last;

    assign par_start = (r_state == S_IDLE) && i_start && !i_job.action;

    scsp_parity u_parity (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (par_start),
        .i_now    (i_job.now),
        .o_done   (par_done),
        .o_parity (par_bit)
    );

    assign wsel   = r_found ? r_chosen : r_old_idx;
    assign wr     = '{parity: r_par, freq: r_freq, stamp: r_now};
    assign ram_we = (r_state == S_PICK);
    assign ram_re = (r_state == S_SCAN) && r_rd_more;

    // writes happen only in PICK, after all reads of the item: no overlap
    scsp_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wsel),
        .i_wdata (wr),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    // evaluate entry r_ev_idx; its registered RAM word arrives in the cycle after the read
    assign rd      = t_entry'(ram_rdata);
    assign live    = r_valid[r_ev_idx];
    assign fdiff   = (rd.freq > r_freq) ? (rd.freq - r_freq) : (r_freq - rd.freq);
    assign hit     = live && (rd.parity == r_par) && (fdiff <= i_cfg.freq_tol);
    assign age     = r_now - rd.stamp;
    assign expired = (rd.stamp > r_now) || (age > TIME_BITS'(i_cfg.max_age));
    assign older   = !r_have_old || (rd.stamp < r_old_t);
    assign last    = (r_ev_idx == LAST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = i_job.action ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                if (par_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_ev_vld && (hit || last)) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: n_state = S_DONE;
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_rd_more <= 1'b0;
            r_ev_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_freq <= i_job.freq;
                        r_now  <= i_job.now;
                        if (i_job.action) begin
                            r_valid  <= '0;
                            r_chosen <= '0;
                            r_kind   <= PL_CLEARED;
                        end
                    end
                end
                S_DIV: begin
                    if (par_done) begin
                        r_par      <= par_bit;
                        r_rd_addr  <= '0;
                        r_rd_more  <= 1'b1;
                        r_ev_vld   <= 1'b0;
                        r_found    <= 1'b0;
                        r_have_old <= 1'b0;
                        r_old_idx  <= '0;
                        r_kind     <= PL_FREE;
                    end
                end
                S_SCAN: begin
                    // a match stops reads; a match or the last entry ends the scan
                    r_ev_vld  <= r_rd_more && !(r_ev_vld && (hit || last));
                    r_ev_idx  <= r_rd_addr;
                    r_rd_addr <= r_rd_addr + 1'b1;
                    r_rd_more <= r_rd_more && (r_rd_addr != LAST) && !(r_ev_vld && hit);
                    if (r_ev_vld) begin
                        if (live) begin
                            if (hit) begin
                                // match ends the scan, later entries untouched
                                r_chosen  <= r_ev_idx;
                                r_found   <= 1'b1;
                                r_kind    <= PL_MATCH;
                            end else if (expired) begin
                                r_valid[r_ev_idx] <= 1'b0;
                                if (!r_found) begin
                                    r_chosen <= r_ev_idx;
                                    r_found  <= 1'b1;
                                end
                            end else if (older) begin
                                r_have_old <= 1'b1;
                                r_old_t    <= rd.stamp;
                                r_old_idx  <= r_ev_idx;
                            end
                        end else if (!r_found) begin
                            r_chosen <= r_ev_idx;
                            r_found  <= 1'b1;
                        end
                    end
                end
                S_PICK: begin
                    r_valid[wsel] <= 1'b1;
                    r_chosen      <= wsel;
                    if (!r_found) begin
                        r_kind <= PL_EVICT;
                    end
                end
                S_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = '{slot: r_chosen, placement: r_kind};
endmodule

### src/scsp_checker.sv
// Port-level checks on the slot cache store policy, bound to the top level.
// Uses scsp_pkg and slot_cache_store_policy_defines.svh.
`include "slot_cache_store_policy_defines.svh"

module scsp_port_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_req_action,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [scsp_pkg::SLOT_W-1:0] i_rsp_slot,
    input logic [1:0]                  i_rsp_place
);
    import scsp_pkg::*;

    logic rsp_clear;
    logic store_take;

    assign rsp_clear  = i_rsp_valid && (i_rsp_place == PL_CLEARED);
    assign store_take = i_req_valid && i_req_ready && !i_req_action;

    // a clear always reports entry zero
    `SCSP_ASSERT_IMP(a_clear_slot_zero, rsp_clear, i_rsp_slot == '0)

    // one request in flight: intake closes right after an accept
    `SCSP_ASSERT_NXT(a_one_in_flight, i_req_valid && i_req_ready, !i_req_ready)

    // a store needs the parity division first, so no response the next cycle if none is pending
    `SCSP_ASSERT_NXT(a_store_not_instant, store_take && !i_rsp_valid, !i_rsp_valid)

    // stalled response holds
    `SCSP_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable({i_rsp_slot, i_rsp_place}))
endmodule

bind slot_cache_store_policy scsp_port_checker u_scsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_action (i_req.action),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_slot   (o_rsp.slot_index),
    .i_rsp_place  (o_rsp.placement)
);

### verif/scsp_tb_pkg.sv
// Request action codes shared by the testbench top and the checker.
// No dependencies.
`timescale 1ns / 100ps

package scsp_tb_pkg;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

endpackage

### verif/scsp_checker.sv
// Checker for the slot cache store policy: mirrors the table and registers,
// predicts one placement per accepted request and compares responses in order.
// Depends on scsp_pkg, scsp_tb_pkg and the channel interfaces in scsp_if.
`timescale 1ns / 100ps

module scsp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    scsp_req_if  i_req,
    scsp_rsp_if  i_rsp,
    scsp_cfg_if  i_cfg,
    output int   o_mismatches,
    output int   o_outstanding
);
    import scsp_pkg::*;
    import scsp_tb_pkg::*;

    // mirrored table and registers
    logic                 live      [ENTRIES];
    logic                 slot_par  [ENTRIES];
    logic [FREQ_W-1:0]    cand_freq [ENTRIES];
    logic [TIME_BITS-1:0] cand_time [ENTRIES];
    logic [TOL_W-1:0]     freq_tol;
    logic [AGE_W-1:0]     max_age;

    t_result placements_due [$];
    t_result want;
    int      mismatch_count;

    function automatic logic time_parity(input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] slot_no;
        slot_no = t / TIME_BITS'(SLOT_MS);
        return slot_no[0];
    endfunction

    // Scan in index order; updates the mirrored table like the block does.
    function automatic t_result place_store(input logic [FREQ_W-1:0]    f,
                                            input logic [TIME_BITS-1:0] now);
        logic                 par;
        logic                 hit;
        logic                 have_old;
        int                   i;
        int                   pick;
        int                   oldest;
        t_place               kind;
        logic [FREQ_W-1:0]    diff;
        logic [TIME_BITS-1:0] oldest_t;
        t_result              res;

        par      = time_parity(now);
        hit      = 1'b0;
        have_old = 1'b0;
        pick     = -1;
        oldest   = 0;
        oldest_t = '0;
        kind     = PL_FREE;
        for (i = 0; i < ENTRIES && !hit; i++) begin
            if (live[i]) begin
                diff = (cand_freq[i] > f) ? cand_freq[i] - f : f - cand_freq[i];
                if (slot_par[i] == par && diff <= freq_tol) begin
                    hit  = 1'b1;
                    pick = i;
                    kind = PL_MATCH;
                end else if (cand_time[i] > now ||
                             now - cand_time[i] > TIME_BITS'(max_age)) begin
                    // future or stale entry: freed on the way
                    live[i] = 1'b0;
                    if (pick < 0) pick = i;
                end else if (!have_old || cand_time[i] < oldest_t) begin
                    have_old = 1'b1;
                    oldest_t = cand_time[i];
                    oldest   = i;
                end
            end else if (pick < 0) begin
                pick = i;
            end
        end
        if (pick < 0) begin
            pick = oldest;
            kind = PL_EVICT;
        end
        live[pick]      = 1'b1;
        slot_par[pick]  = par;
        cand_freq[pick] = f;
        cand_time[pick] = now;
        res.slot      = IDX_W'(pick);
        res.placement = kind;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (live[i]) begin
                live[i]      = 1'b0;
                slot_par[i]  = 1'b0;
                cand_freq[i] = '0;
                cand_time[i] = '0;
            end
            freq_tol = TOL_RESET;
            max_age  = AGE_RESET;
            placements_due.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_FREQ_TOL: freq_tol = i_cfg.data[TOL_W-1:0];
                    CFG_MAX_AGE:  max_age  = i_cfg.data[AGE_W-1:0];
                    default: ;
                endcase
            end
            // responses first: a request taken this cycle cannot answer in it
            if (i_rsp.valid && i_rsp.ready) begin
                if (placements_due.size() == 0) begin
                    $error("unexpected response: slot_index %0d placement %0d",
                           i_rsp.slot_index, i_rsp.placement);
                    mismatch_count++;
                end else begin
                    want = placements_due.pop_front();
                    if (i_rsp.slot_index !== want.slot) begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot, i_rsp.slot_index);
                        mismatch_count++;
                    end
                    if (i_rsp.placement !== want.placement) begin
                        $error("placement: expected %0d, actual %0d",
                               want.placement, i_rsp.placement);
                        mismatch_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.action == ACT_CLEAR) begin
                    foreach (live[i]) live[i] = 1'b0;
                    want.slot      = '0;
                    want.placement = PL_CLEARED;
                    placements_due.push_back(want);
                end else begin
                    placements_due.push_back(place_store(i_req.freq, i_req.time_ms));
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= placements_due.size();
    end

endmodule

### verif/tb_top.sv
// Testbench top for the slot cache store policy: clock, reset, request and
// register stimulus, response back-pressure, watchdog and final verdict.
// Depends on scsp_pkg, scsp_tb_pkg, scsp_if, scsp_checker and the RTL.
`timescale 1ns / 100ps

module tb_top;
    import scsp_pkg::*;
    import scsp_tb_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 5;
    // Even a full store scan with sender gaps and receiver stalls leaves
    // no quiet stretch this long, so reaching the limit means a hang.
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 240;
    // more frequencies than table entries so the table can fill and evict
    localparam int POOL_SIZE    = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int tx_idle_pct;
    int rx_idle_pct;
    int mismatches;
    int outstanding;
    int quiet_cycles = 0;

    scsp_req_if req_ch ();
    scsp_rsp_if rsp_ch ();
    scsp_cfg_if cfg_ch ();

    slot_cache_store_policy DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    scsp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .i_cfg         (cfg_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Response back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog: any accepted request, response or register write rearms it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) ||
            (rsp_ch.valid && rsp_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One request: optional idle gap, then hold valid until accepted.
    // Valid is left high on exit so back-to-back requests never toggle it.
    task automatic put_req(input logic              act,
                           input logic [FREQ_W-1:0] f,
                           input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.freq    <= f;
        req_ch.time_ms <= t;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Every request yields one response, so zero outstanding means idle.
    // The first edge lets the checker count a request taken this cycle.
    task automatic wait_drained();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Both registers, written back to back while the block is idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] tol_word,
                              input logic [CFG_DATA_W-1:0] age_word);
        req_ch.valid <= 1'b0;
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_FREQ_TOL;
        cfg_ch.data  <= tol_word;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.index <= CFG_MAX_AGE;
        cfg_ch.data  <= age_word;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Directed part, register defaults (tolerance 48, max age 60000 ms).
    task automatic run_directed();
        put_req(ACT_STORE, 16'd1000, TIME_W'(100000));  // empty table: entry 0
        put_req(ACT_STORE, 16'd1048, TIME_W'(100500));  // diff == tolerance: refresh
        put_req(ACT_STORE, 16'd1100, TIME_W'(101000));  // diff 52: new entry
        put_req(ACT_STORE, 16'd1000, TIME_W'(115000));  // other slot parity
        put_req(ACT_STORE, 16'd0, TIME_W'(0));          // all entries in the future
        put_req(ACT_STORE, 16'hFFFF, '1);               // top time, stale entry freed
        put_req(ACT_STORE, 16'hFFFF, '1);               // exact refresh
        put_req(ACT_STORE, 16'd65500, '1);              // item below entry frequency
        put_req(ACT_CLEAR, 16'd0, '0);
        put_req(ACT_STORE, 16'd500, TIME_W'(200000));
        put_req(ACT_STORE, 16'd2000, TIME_W'(255000));
        // entry 0 is stale and freed, yet the match at entry 1 still wins
        put_req(ACT_STORE, 16'd2010, TIME_W'(262000));
        put_req(ACT_STORE, 16'd5000, TIME_W'(322000));  // age exactly max: kept
        put_req(ACT_STORE, 16'd6000, TIME_W'(322001));  // one ms past max: freed
        put_req(ACT_CLEAR, 16'hFFFF, '1);
    endtask

    // Random part under one register setting: a drifting clock and a pool of
    // candidate frequencies with jitter, plus clears, noise and clock steps back.
    task automatic run_phase(input int ph);
        int                    r;
        int                    n;
        int                    step;
        int                    jit;
        int                    off;
        logic [TOL_W-1:0]      tol;
        logic [AGE_W-1:0]      age;
        logic [CFG_DATA_W-1:0] tol_word;
        logic [TIME_W-1:0]     base;
        logic [FREQ_W-1:0]     f;
        logic [FREQ_W-1:0]     pool [POOL_SIZE];

        case (ph)
            0: begin tol = TOL_W'(48);  age = 60000;    step = 400;   jit = 60;  end
            1: begin tol = '0;          age = '1;       step = 2000;  jit = 2;   end
            2: begin tol = '1;          age = 0;        step = 50;    jit = 100; end
            3: begin tol = TOL_W'(300); age = 20000;    step = 3000;  jit = 400; end
            4: begin tol = TOL_W'(7);   age = 1000000;  step = 10000; jit = 10;  end
            default: begin
                tol = TOL_W'($urandom); age = $urandom; step = 5000;  jit = 64;
            end
        endcase
        tol_word = CFG_DATA_W'(tol);
        if (ph >= 5) begin
            // unused upper data bits must be ignored
            tol_word = $urandom;
            tol_word[TOL_W-1:0] = tol;
        end
        set_config(tol_word, CFG_DATA_W'(age));

        foreach (pool[i]) pool[i] = FREQ_W'($urandom);
        base = TIME_W'({$urandom, $urandom});

        for (n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 1) begin
                put_req(ACT_CLEAR, FREQ_W'($urandom), TIME_W'({$urandom, $urandom}));
            end else if (r < 7) begin
                // noise: any frequency, any time
                put_req(ACT_STORE, FREQ_W'($urandom), TIME_W'({$urandom, $urandom}));
            end else begin
                if (r < 11) begin
                    // clock steps back: older entries now lie in the future
                    base = base - TIME_W'($urandom_range(1, 4 * step));
                end else if ($urandom_range(0, 99) >= 40) begin
                    base = base + TIME_W'($urandom_range(1, step));
                end
                // otherwise same time as before: equally old entries
                off = 0;
                if ($urandom_range(0, 1)) off = int'($urandom_range(0, 2 * jit)) - jit;
                f = FREQ_W'(int'(pool[$urandom_range(0, POOL_SIZE - 1)]) + off);
                put_req(ACT_STORE, f, base);
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.action  <= ACT_STORE;
        req_ch.freq    <= '0;
        req_ch.time_ms <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_FREQ_TOL;
        cfg_ch.data    <= '0;
        tx_idle_pct    <= 33;
        rx_idle_pct    <= 56;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // slow sender against a slower receiver
        run_directed();
        run_phase(0);
        run_phase(1);
        // roles swapped
        tx_idle_pct <= 56;
        rx_idle_pct <= 33;
        run_phase(2);
        run_phase(3);
        // full rate both ways
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        run_phase(4);
        run_phase(5);

        req_ch.valid <= 1'b0;
        wait_drained();
        // catch any stray response after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### slot_cache_store_policy.f
+incdir+src
src/scsp_pkg.sv
src/scsp_if.sv
src/scsp_ram.sv
src/scsp_parity.sv
src/scsp_scan.sv
src/slot_cache_store_policy.sv
src/scsp_checker.sv
verif/scsp_tb_pkg.sv
verif/scsp_checker.sv
verif/tb_top.sv
